### design/upd_pkg.sv
package upd_pkg;

  localparam logic [7:0] PctSign = 8'h25;
  localparam int unsigned MaxOut = 3;

  // words produced by one input byte, oldest in slot 0
  typedef struct packed {
    logic [1:0]                cnt;
    logic [MaxOut-1:0][7:0]    bytes;
    logic                      str_end;
  } res_t;

endpackage

### design/url_percent_decoder_top.sv
// channel | valid      | stall       | payload
// in      | in_valid_i | in_stall_o  | in_byte_i, in_last_i
// out     | out_valid_o| out_stall_i | out_byte_o, run_last_o, string_end_o
//
// one input word per cycle while each gives at most one word, out_stall_i low
// an input word yielding two or three output words holds in_stall_o while the
// 3-entry output buffer drains one word per cycle unless out_stall_i is high
// rst_ni clears the decode mode and empties the output buffer, no clearing pass
// in_stall_o also follows out_stall_i when the buffer holds its final word
module url_percent_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       string_end_o
);

  upd_pkg::res_t res;
  logic          take;

  assign take = in_valid_i && !in_stall_o;

  upd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .in_byte_i (in_byte_i),
    .in_last_i (in_last_i),
    .res_o     (res)
  );

  upd_outq u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .res_i        (res),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o)
  );

endmodule

### design/upd_core.sv
module upd_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            take_i,
  input  logic [7:0]      in_byte_i,
  input  logic            in_last_i,
  output upd_pkg::res_t   res_o
);

  typedef enum logic [1:0] {
    ModeIdle = 2'd0,
    ModePct  = 2'd1,
    ModePct1 = 2'd2
  } mode_e;

  mode_e      mode_q, mode_d;
  logic [7:0] first_q, first_d;

  // returns {hit, value} for the fixed escape set, upper-case hex only
  function automatic logic [8:0] escape_lookup(logic [7:0] hi, logic [7:0] lo);
    logic       hit;
    logic [3:0] lo_val;
    hit    = 1'b0;
    lo_val = lo[3:0];
    if (lo >= 8'h41 && lo <= 8'h46) begin
      lo_val = lo[3:0] + 4'd9;
    end
    case (hi)
      8'h32: hit = (lo == 8'h30) || (lo >= 8'h32 && lo <= 8'h39) ||
                   (lo == 8'h42) || (lo == 8'h43) || (lo == 8'h46);
      8'h33: hit = (lo >= 8'h41 && lo <= 8'h46);
      8'h34: hit = (lo == 8'h30);
      8'h35: hit = (lo >= 8'h42 && lo <= 8'h46);
      8'h37: hit = (lo >= 8'h42 && lo <= 8'h45);
      default: hit = 1'b0;
    endcase
    return {hit, hi[3:0], lo_val};
  endfunction

  always_comb begin
    logic [8:0] look;
    logic [1:0] n;
    logic [2:0][7:0] buf_w;
    look   = escape_lookup(first_q, in_byte_i);
    n      = 2'd0;
    buf_w  = '0;
    mode_d  = mode_q;
    first_d = first_q;
    case (mode_q)
      ModePct: begin
        first_d = in_byte_i;
        mode_d  = ModePct1;
      end
      ModePct1: begin
        if (look[8]) begin
          buf_w[n] = look[7:0];
          n = n + 2'd1;
          mode_d = ModeIdle;
        end else begin
          buf_w[n] = upd_pkg::PctSign;
          n = n + 2'd1;
          if (first_q == upd_pkg::PctSign) begin
            // pending byte reopens an escape, current byte becomes its first digit
            first_d = in_byte_i;
            mode_d  = ModePct1;
          end else begin
            buf_w[n] = first_q;
            n = n + 2'd1;
            if (in_byte_i == upd_pkg::PctSign) begin
              mode_d = ModePct;
            end else begin
              buf_w[n] = in_byte_i;
              n = n + 2'd1;
              mode_d = ModeIdle;
            end
          end
        end
      end
      default: begin
        if (in_byte_i == upd_pkg::PctSign) begin
          mode_d = ModePct;
        end else begin
          buf_w[n] = in_byte_i;
          n = n + 2'd1;
          mode_d = ModeIdle;
        end
      end
    endcase
    if (in_last_i) begin
      // flush whatever is still pending at string end
      if (mode_d == ModePct) begin
        buf_w[n] = upd_pkg::PctSign;
        n = n + 2'd1;
      end else if (mode_d == ModePct1) begin
        buf_w[n] = upd_pkg::PctSign;
        n = n + 2'd1;
        buf_w[n] = first_d;
        n = n + 2'd1;
      end
      mode_d  = ModeIdle;
      first_d = 8'h00;
    end
    res_o.cnt     = n;
    res_o.bytes   = buf_w;
    res_o.str_end = in_last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      first_q <= 8'h00;
    end else if (take_i) begin
      mode_q  <= mode_d;
      first_q <= first_d;
    end
  end

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && in_last_i |=> mode_q == ModeIdle && first_q == 8'h00)
    else $error("state not cleared after string end");

  a_last_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && in_last_i |-> res_o.cnt != 2'd0)
    else $error("string end produced no word");

  a_mode_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != 2'd3)
    else $error("decode mode left its legal codes");

endmodule

### design/upd_outq.sv
module upd_outq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  upd_pkg::res_t   res_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o,
  output logic            string_end_o
);

  logic [1:0]      cnt_q, cnt_d;
  logic [2:0][7:0] byte_q, byte_d;
  logic            end_q, end_d;
  logic            pop, load_ok, take;

  assign pop     = (cnt_q != 2'd0) && !out_stall_i;
  // a new batch may land once the last word of the old one leaves
  assign load_ok = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && !out_stall_i);
  assign take    = in_valid_i && load_ok;

  assign in_stall_o   = !load_ok;
  assign out_valid_o  = cnt_q != 2'd0;
  assign out_byte_o   = byte_q[0];
  assign run_last_o   = cnt_q == 2'd1;
  assign string_end_o = (cnt_q == 2'd1) && end_q;

  always_comb begin
    cnt_d  = cnt_q;
    byte_d = byte_q;
    end_d  = end_q;
    if (take) begin
      cnt_d  = res_i.cnt;
      byte_d = res_i.bytes;
      end_d  = res_i.str_end;
    end else if (pop) begin
      cnt_d     = cnt_q - 2'd1;
      byte_d[0] = byte_q[1];
      byte_d[1] = byte_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      end_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      end_q <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  a_take_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> cnt_q == 2'd0 || (cnt_q == 2'd1 && !out_stall_i))
    else $error("batch loaded over undelivered words");

  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    string_end_o |-> run_last_o && out_valid_o)
    else $error("string end without run end");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o))
    else $error("stalled word changed");

endmodule

### tb/url_percent_decoder_top_tb.sv
`timescale 1ns / 100ps

module url_percent_decoder_top_tb;

  localparam int unsigned HoldCycles    = 200;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned IdlePct       = 32;
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned NumEscapes    = 28;

  localparam logic [7:0] EscapeCodes [NumEscapes] = '{
    8'h20, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2B, 8'h2C, 8'h2F,
    8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40,
    8'h5B, 8'h5C, 8'h5D, 8'h5E, 8'h5F,
    8'h7B, 8'h7C, 8'h7D, 8'h7E
  };

  typedef enum logic [1:0] {
    ScanIdle   = 2'd0,
    ScanPct    = 2'd1,
    ScanPctHex = 2'd2
  } scan_mode_e;

  typedef struct {
    logic [7:0] data;
    logic       run_last;
    logic       string_end;
  } dec_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       in_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       run_last_o;
  logic       string_end_o;

  url_percent_decoder_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o)
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  scan_mode_e  scan_mode = ScanIdle;
  logic [7:0]  held_char = 8'h00;
  dec_word_t   decoded_q[$];
  int unsigned fail_cnt = 0;

  bit          idle_on = 1'b1;
  int unsigned hold_req_cnt = 0;
  int unsigned hold_ack_cnt = 0;
  int unsigned hold_left = 0;
  int unsigned stuck_cycles = 0;

  function automatic int hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 10) ? 8'("0") + 8'(n) : 8'("A") + 8'(n) - 8'd10;
  endfunction

  function automatic bit escape_value(input logic [7:0] hi, input logic [7:0] lo,
                                      output logic [7:0] val);
    int h;
    int l;
    h = hex_value(hi);
    l = hex_value(lo);
    val = 8'(h * 16 + l);
    if (h < 0 || l < 0) return 1'b0;
    foreach (EscapeCodes[k]) begin
      if (EscapeCodes[k] == val) return 1'b1;
    end
    return 1'b0;
  endfunction

  // plain byte while idle: a percent opens an escape, anything else passes
  function automatic void scan_plain(input logic [7:0] b, ref logic [7:0] words[$]);
    if (b == upd_pkg::PctSign) scan_mode = ScanPct;
    else words.push_back(b);
  endfunction

  function automatic void predict_decode(input logic [7:0] b, input logic last);
    logic [7:0] words[$];
    logic [7:0] val;
    dec_word_t  w;
    case (scan_mode)
      ScanPct: begin
        held_char = b;
        scan_mode = ScanPctHex;
      end
      ScanPctHex: begin
        if (escape_value(held_char, b, val)) begin
          words.push_back(val);
          scan_mode = ScanIdle;
        end else begin
          // unknown escape: percent passes, both bytes are looked at again
          words.push_back(upd_pkg::PctSign);
          if (held_char == upd_pkg::PctSign) begin
            held_char = b;
            scan_mode = ScanPctHex;
          end else begin
            words.push_back(held_char);
            scan_mode = ScanIdle;
            scan_plain(b, words);
          end
        end
      end
      default: begin
        scan_mode = ScanIdle;
        scan_plain(b, words);
      end
    endcase
    if (last) begin
      if (scan_mode == ScanPct) begin
        words.push_back(upd_pkg::PctSign);
      end else if (scan_mode == ScanPctHex) begin
        words.push_back(upd_pkg::PctSign);
        words.push_back(held_char);
      end
      scan_mode = ScanIdle;
      held_char = 8'h00;
    end
    foreach (words[k]) begin
      w.data       = words[k];
      w.run_last   = (k == words.size() - 1);
      w.string_end = w.run_last && last;
      decoded_q.push_back(w);
    end
  endfunction

  function automatic void check_word(input logic [7:0] b, input logic rl, input logic se);
    dec_word_t w;
    if (decoded_q.size() == 0) begin
      $error("unexpected word: out_byte %0h run_last %0b string_end %0b", b, rl, se);
      fail_cnt++;
      return;
    end
    w = decoded_q.pop_front();
    if (b !== w.data) begin
      $error("out_byte: expected %0h, actual %0h", w.data, b);
      fail_cnt++;
    end
    if (rl !== w.run_last) begin
      $error("run_last: expected %0b, actual %0b", w.run_last, rl);
      fail_cnt++;
    end
    if (se !== w.string_end) begin
      $error("string_end: expected %0b, actual %0b", w.string_end, se);
      fail_cnt++;
    end
  endfunction

  // input side predicted first; a word leaving in the same cycle was predicted earlier
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_decode(in_byte_i, in_last_i);
      if (out_valid_o && !out_stall_i) check_word(out_byte_o, run_last_o, string_end_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // receiver: random stalls, or a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_ack_cnt != hold_req_cnt) begin
      out_stall_i  <= 1'b1;
      hold_left    <= HoldCycles - 1;
      hold_ack_cnt <= hold_req_cnt;
    end else begin
      out_stall_i <= idle_on && ($urandom_range(0, 99) < IdlePct);
    end
  end

  // called and returns at a falling edge; valid stays high until the next word or idle
  task automatic send_word(input logic [7:0] b, input logic last);
    while (idle_on && ($urandom_range(0, 99) < IdlePct)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic send_string(input logic [7:0] s[$]);
    foreach (s[k]) send_word(s[k], k == s.size() - 1);
  endtask

  function automatic logic [7:0] loose_hex_char();
    int unsigned r;
    r = $urandom_range(0, 22);
    if (r < 16) return hex_char(4'(r));
    if (r < 22) return 8'("a") + 8'(r - 16);
    return upd_pkg::PctSign;
  endfunction

  // well-formed escapes most often, with broken ones, stray percents and raw bytes
  function automatic void make_string(output logic [7:0] s[$]);
    int unsigned parts;
    int unsigned r;
    logic [7:0]  code;
    s.delete();
    parts = $urandom_range(1, 6);
    repeat (parts) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        code = EscapeCodes[$urandom_range(0, NumEscapes - 1)];
        s.push_back(upd_pkg::PctSign);
        s.push_back(hex_char(code[7:4]));
        s.push_back(hex_char(code[3:0]));
      end else if (r < 60) begin
        s.push_back(upd_pkg::PctSign);
        s.push_back(loose_hex_char());
        s.push_back(loose_hex_char());
      end else if (r < 68) begin
        s.push_back(upd_pkg::PctSign);
      end else begin
        s.push_back(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  task automatic send_random(input int unsigned n_items);
    logic [7:0]  s[$];
    int unsigned sent;
    sent = 0;
    while (sent < n_items) begin
      make_string(s);
      send_string(s);
      sent += s.size();
    end
  endtask

  task automatic test_directed();
    send_string('{8'h00, upd_pkg::PctSign, "2", "0", 8'hFF});
    // decoded percent is not rescanned
    send_string('{upd_pkg::PctSign, "2", "5", "4", "1"});
    // lower-case hex is left alone
    send_string('{upd_pkg::PctSign, "2", "a", upd_pkg::PctSign, "7", "E"});
    send_string('{upd_pkg::PctSign, upd_pkg::PctSign, "2", "0"});
    // percent near the end of the string
    send_string('{"a", upd_pkg::PctSign});
    send_string('{upd_pkg::PctSign, "4"});
    send_string('{upd_pkg::PctSign});
  endtask

  task automatic test_no_idling();
    idle_on = 1'b0;
    send_random(60);
    idle_on = 1'b1;
  endtask

  task automatic test_output_hold();
    hold_req_cnt++;
    send_random(60);
  endtask

  task automatic test_random();
    send_random(215);
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_no_idling();
    test_output_hold();
    test_random();
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0 && decoded_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
design/upd_pkg.sv
design/upd_core.sv
design/upd_outq.sv
design/url_percent_decoder_top.sv
tb/url_percent_decoder_top_tb.sv
